// ===== rtl/core/mrn_pkg.sv =====
package mrn_pkg;

    // fixed field widths
    localparam int CELL_W = 32;
    localparam int ADDR_W = 64;
    localparam int CAP_W  = 5;
    localparam int CELLS_W = 2;

    // parameter defaults
    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_SHIFT_DEF  = 12;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_CELLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_CELLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd2;

    // legal cell counts
    localparam logic [CELLS_W-1:0] CELLS_ONE = 2'd1;
    localparam logic [CELLS_W-1:0] CELLS_TWO = 2'd2;

    // outcome codes
    localparam logic [1:0] OUTCOME_VALID    = 2'd0;
    localparam logic [1:0] OUTCOME_EMPTY    = 2'd1;
    localparam logic [1:0] OUTCOME_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [CELL_W-1:0] base_upper_cell;
        logic [CELL_W-1:0] base_lower_cell;
        logic [CELL_W-1:0] size_upper_cell;
        logic [CELL_W-1:0] size_lower_cell;
        logic              final_range;
    } range_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
        logic [1:0]        outcome;
        logic              last_region;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } region_t;

    typedef struct packed {
        logic    valid;
        logic    keep;
        region_t span;
    } prep_t;

endpackage

// ===== rtl/core/mrn_region_ram.sv =====
module mrn_region_ram
    import mrn_pkg::*;
#(
    parameter int DEPTH = MAX_REGIONS_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  region_t          wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output region_t          rd_data
);

    region_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mrn_range_prep.sv =====
module mrn_range_prep
    import mrn_pkg::*;
#(
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  range_in_t          item,
    input  logic [CELLS_W-1:0] addr_cells,
    input  logic [CELLS_W-1:0] len_cells,
    output prep_t              prep
);

    localparam logic [ADDR_W-1:0] LOW_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

    logic [ADDR_W-1:0] base_c;
    logic [ADDR_W-1:0] size_c;
    logic [ADDR_W:0]   sum_c;
    logic              ok_c;
    logic [ADDR_W-1:0] rounded_c;
    logic [ADDR_W-1:0] trunc_c;

    logic              v1_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] top_reg;
    logic              ok1_reg;
    logic              valid_reg;
    logic              keep_reg;
    region_t           span_reg;

    // stage 1: join cells, form top, screen out bad ranges
    always_comb
    begin
        base_c = (addr_cells == CELLS_TWO) ? {item.base_upper_cell, item.base_lower_cell}
                                           : {CELL_W'(0), item.base_lower_cell};
        size_c = (len_cells == CELLS_TWO) ? {item.size_upper_cell, item.size_lower_cell}
                                          : {CELL_W'(0), item.size_lower_cell};
        sum_c  = {1'b0, base_c} + {1'b0, size_c};
        ok_c   = (size_c != '0) && !sum_c[ADDR_W] && (base_c <= ~LOW_MASK);
    end

    // stage 2: page rounding
    always_comb
    begin
        rounded_c = (base_reg + LOW_MASK) & ~LOW_MASK;
        trunc_c   = top_reg & ~LOW_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= load;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg <= base_c;
            top_reg  <= sum_c[ADDR_W-1:0];
            ok1_reg  <= ok_c;
        end
        if (v1_reg)
        begin
            keep_reg            <= ok1_reg && (rounded_c < trunc_c);
            span_reg.start_addr <= rounded_c;
            span_reg.end_addr   <= trunc_c;
        end
    end

    assign prep.valid = valid_reg;
    assign prep.keep  = keep_reg;
    assign prep.span  = span_reg;

endmodule

// ===== rtl/core/memory_region_normalizer_core.sv =====
// channel   | signals                         | handshake
// ----------+---------------------------------+-------------------------------------
// input     | start, busy, item               | word taken when start high, busy low
// result    | done, result                    | word valid for the one cycle done high
// config    | cfg_we, cfg_index, cfg_data     | register written when cfg_we high
//
// a word that stores nothing or lands in an empty store keeps busy high through two prep
// stages and the wrap-up step; an insert into a non-empty store moves stored entries up from
// the top until the new range fits, with ram read data registered; a final word then walks
// every stored entry to merge them; results come on done at most one per cycle, an error
// word and the last word in the cycle that busy drops; rst_n clears control state, sets two
// cells and capacity 16; the receiver cannot stall
module memory_region_normalizer_core
    import mrn_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  range_in_t             item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_WRAP   = 3'd4;
    localparam logic [2:0] S_MFIRST = 3'd5;
    localparam logic [2:0] S_MERGE  = 3'd6;
    localparam logic [2:0] S_MLAST  = 3'd7;

    // configuration registers
    logic [CELLS_W-1:0] addr_cells_reg;
    logic [CELLS_W-1:0] len_cells_reg;
    logic [CAP_W-1:0]   capacity_reg;

    // sequencer and list state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             overflow_reg, overflow_next;
    logic             final_reg;
    logic [ADDR_W-1:0] cs_reg, cs_next;
    logic [ADDR_W-1:0] ce_reg, ce_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    // ram port signals
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    region_t          wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    region_t          rd_data;

    prep_t prep;

    logic             accept;
    logic             cfg_ok;
    logic             count_full;
    logic             take;
    logic [CNT_W-1:0] ptr_m1, ptr_m2, ptr_p1, count_m1;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_cells_reg <= CELLS_TWO;
            len_cells_reg  <= CELLS_TWO;
            capacity_reg   <= CAP_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADDR_CELLS: addr_cells_reg <= cfg_data[CELLS_W-1:0];
                REG_SIZE_CELLS: len_cells_reg  <= cfg_data[CELLS_W-1:0];
                REG_CAPACITY:   capacity_reg   <= cfg_data[CAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // cell counts must be one or two, capacity non-zero
    assign cfg_ok = ((addr_cells_reg == CELLS_ONE) || (addr_cells_reg == CELLS_TWO)) &&
                    ((len_cells_reg == CELLS_ONE) || (len_cells_reg == CELLS_TWO)) &&
                    (capacity_reg != '0);

    // effective capacity is the smaller of the register and the ram depth
    assign count_full = (count_reg == CNT_W'(MAX_REGIONS)) ||
                        (CMP_W'(count_reg) >= CMP_W'(capacity_reg));

    // a fresh range that survived prep and may go into the store
    assign take = prep.valid && prep.keep && cfg_ok && !overflow_reg;

    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign ptr_m2   = ptr_reg - CNT_W'(2);
    assign ptr_p1   = ptr_reg + CNT_W'(1);
    assign count_m1 = count_reg - CNT_W'(1);

    mrn_range_prep #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .item       (item),
        .addr_cells (addr_cells_reg),
        .len_cells  (len_cells_reg),
        .prep       (prep)
    );

    mrn_region_ram #(
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer: sorted insert by shifting entries up, then merge walk on the final word
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        overflow_next = overflow_reg;
        cs_next       = cs_reg;
        ce_next       = ce_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg[IDX_W-1:0];
        wr_data       = prep.span;
        rd_en         = 1'b0;
        rd_addr       = ptr_m1[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                if (prep.valid)
                begin
                    state_next = S_WRAP;
                    if (take && count_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else if (take && (count_reg == '0))
                    begin
                        // empty store: straight into entry zero
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (take)
                    begin
                        // fetch the top entry, walk downwards from there
                        rd_en      = 1'b1;
                        rd_addr    = count_m1[IDX_W-1:0];
                        ptr_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // rd_data holds entry ptr-1
                if (rd_data.start_addr > prep.span.start_addr)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    ptr_next = ptr_m1;
                    if (ptr_reg == CNT_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = ptr_m2[IDX_W-1:0];
                    end
                end
                else
                begin
                    // equal starts stay ahead of the new range
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_WRAP;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_WRAP;
            end

            S_WRAP:
            begin
                if (!final_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!cfg_ok || overflow_reg || (count_reg == '0))
                begin
                    done_next                = 1'b1;
                    result_next.region_start = '0;
                    result_next.region_end   = '0;
                    result_next.outcome      = (cfg_ok && overflow_reg) ? OUTCOME_OVERFLOW
                                                                        : OUTCOME_EMPTY;
                    result_next.last_region  = 1'b1;
                    count_next               = '0;
                    overflow_next            = 1'b0;
                    state_next               = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    ptr_next   = CNT_W'(1);
                    state_next = S_MFIRST;
                end
            end

            S_MFIRST:
            begin
                cs_next = rd_data.start_addr;
                ce_next = rd_data.end_addr;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_MLAST;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg[IDX_W-1:0];
                    state_next = S_MERGE;
                end
            end

            S_MERGE:
            begin
                // rd_data holds entry ptr
                if (rd_data.start_addr <= ce_reg)
                begin
                    if (rd_data.end_addr > ce_reg)
                    begin
                        ce_next = rd_data.end_addr;
                    end
                end
                else
                begin
                    done_next                = 1'b1;
                    result_next.region_start = cs_reg;
                    result_next.region_end   = ce_reg;
                    result_next.outcome      = OUTCOME_VALID;
                    result_next.last_region  = 1'b0;
                    cs_next                  = rd_data.start_addr;
                    ce_next                  = rd_data.end_addr;
                end
                if (ptr_reg == count_m1)
                begin
                    state_next = S_MLAST;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_p1[IDX_W-1:0];
                    ptr_next = ptr_p1;
                end
            end

            S_MLAST:
            begin
                done_next                = 1'b1;
                result_next.region_start = cs_reg;
                result_next.region_end   = ce_reg;
                result_next.outcome      = OUTCOME_VALID;
                result_next.last_region  = 1'b1;
                count_next               = '0;
                overflow_next            = 1'b0;
                state_next               = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            done_reg     <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            final_reg <= item.final_range;
        end
        ptr_reg    <= ptr_next;
        cs_reg     <= cs_next;
        ce_reg     <= ce_next;
        result_reg <= result_next;
    end

    // the list ends with the block idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last_region |-> !busy)
        else $error("last word of a list while still busy");

    // error words always close the list
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.outcome != OUTCOME_VALID) |-> result.last_region)
        else $error("error word not marked last");

    // stored count never passes the ram depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("stored count beyond ram depth");

    // overflow only once the store is full, and the store then stays put
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> count_full)
        else $error("overflow flagged with room left");

    // no ram write outside an insert
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_PREP) || (state_reg == S_SHIFT) || (state_reg == S_PLACE))
        else $error("ram written outside insert");

endmodule

// ===== dv/region_list_checker.sv =====
module region_list_checker
    import mrn_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  range_in_t             item,
    input  logic                  done,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    pending,
    output int                    checked_count,
    output int                    error_word_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] PAGE_LOW  = (64'd1 << PAGE_SHIFT) - 64'd1;
    localparam logic [ADDR_W-1:0] PAGE_MASK = ~PAGE_LOW;

    // register copies
    logic [CELLS_W-1:0] addr_cells;
    logic [CELLS_W-1:0] len_cells;
    logic [CAP_W-1:0]   capacity;

    // sorted region store
    logic [ADDR_W-1:0] region_starts [MAX_REGIONS];
    logic [ADDR_W-1:0] region_ends   [MAX_REGIONS];
    int                region_count;
    logic              overflow;

    result_t expected_regions [$];
    int      mismatch_total;
    int      checked_total;
    int      error_total;

    function automatic logic [ADDR_W-1:0] join_cells(logic [CELL_W-1:0] upper,
                                                     logic [CELL_W-1:0] lower,
                                                     logic [CELLS_W-1:0] cells);
        return (cells == CELLS_TWO) ? {upper, lower} : {{(ADDR_W-CELL_W){1'b0}}, lower};
    endfunction

    function automatic result_t make_word(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e,
                                          logic [1:0] oc, logic last);
        result_t w;
        w.region_start = s;
        w.region_end   = e;
        w.outcome      = oc;
        w.last_region  = last;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_total++;
    endtask

    // store one range and, on the final word, queue the merged list
    task automatic predict_regions(range_in_t w);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        logic [ADDR_W-1:0] cs;
        logic [ADDR_W-1:0] ce;
        bit                cfg_ok;
        int                cap;
        int                i;
        int                j;
        cfg_ok = (addr_cells == CELLS_ONE || addr_cells == CELLS_TWO) &&
                 (len_cells == CELLS_ONE || len_cells == CELLS_TWO) &&
                 capacity != '0;
        cap = (int'(capacity) > MAX_REGIONS) ? MAX_REGIONS : int'(capacity);
        if (cfg_ok && !overflow)
        begin
            base = join_cells(w.base_upper_cell, w.base_lower_cell, addr_cells);
            size = join_cells(w.size_upper_cell, w.size_lower_cell, len_cells);
            top  = base + size;
            if (size != '0 && top >= base && base <= PAGE_MASK)
            begin
                s = (base + PAGE_LOW) & PAGE_MASK;
                e = top & PAGE_MASK;
                if (s < e)
                begin
                    if (region_count >= cap)
                    begin
                        overflow = 1'b1;
                    end
                    else
                    begin
                        // equal starts go behind the ones already held
                        j = region_count;
                        while (j > 0 && region_starts[j-1] > s)
                        begin
                            region_starts[j] = region_starts[j-1];
                            region_ends[j]   = region_ends[j-1];
                            j--;
                        end
                        region_starts[j] = s;
                        region_ends[j]   = e;
                        region_count++;
                    end
                end
            end
        end
        if (w.final_range)
        begin
            if (!cfg_ok)
            begin
                expected_regions.push_back(make_word('0, '0, OUTCOME_EMPTY, 1'b1));
            end
            else if (overflow)
            begin
                expected_regions.push_back(make_word('0, '0, OUTCOME_OVERFLOW, 1'b1));
            end
            else if (region_count == 0)
            begin
                expected_regions.push_back(make_word('0, '0, OUTCOME_EMPTY, 1'b1));
            end
            else
            begin
                cs = region_starts[0];
                ce = region_ends[0];
                for (i = 1; i < region_count; i++)
                begin
                    if (region_starts[i] <= ce)
                    begin
                        if (region_ends[i] > ce)
                        begin
                            ce = region_ends[i];
                        end
                    end
                    else
                    begin
                        expected_regions.push_back(make_word(cs, ce, OUTCOME_VALID, 1'b0));
                        cs = region_starts[i];
                        ce = region_ends[i];
                    end
                end
                expected_regions.push_back(make_word(cs, ce, OUTCOME_VALID, 1'b1));
            end
            region_count = 0;
            overflow     = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            addr_cells     = CELLS_TWO;
            len_cells      = CELLS_TWO;
            capacity       = CAP_W'(16);
            region_count   = 0;
            overflow       = 1'b0;
            mismatch_total = 0;
            checked_total  = 0;
            error_total    = 0;
            expected_regions.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_regions.size() == 0)
                begin
                    report_mismatch("result word with none expected", result.region_start, '0);
                end
                else
                begin
                    want = expected_regions.pop_front();
                    if (result.region_start !== want.region_start)
                        report_mismatch("region_start", result.region_start, want.region_start);
                    if (result.region_end !== want.region_end)
                        report_mismatch("region_end", result.region_end, want.region_end);
                    if (result.outcome !== want.outcome)
                        report_mismatch("outcome", ADDR_W'(result.outcome), ADDR_W'(want.outcome));
                    if (result.last_region !== want.last_region)
                        report_mismatch("last_region", ADDR_W'(result.last_region),
                                        ADDR_W'(want.last_region));
                    checked_total++;
                    if (want.outcome != OUTCOME_VALID)
                        error_total++;
                end
            end
            if (start && !busy)
            begin
                predict_regions(item);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ADDR_CELLS: addr_cells = cfg_data[CELLS_W-1:0];
                    REG_SIZE_CELLS: len_cells  = cfg_data[CELLS_W-1:0];
                    REG_CAPACITY:   capacity   = cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end
        end
        error_count      <= mismatch_total;
        pending          <= expected_regions.size();
        checked_count    <= checked_total;
        error_word_count <= error_total;
    end

endmodule

// ===== dv/memory_region_normalizer_core_tb.sv =====
module memory_region_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrn_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 410;
    // worst word: shift of a full store, then merge walk of sixteen entries
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    range_in_t             item      = '0;
    logic                  done;
    result_t               result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int error_count;
    int pending;
    int checked_count;
    int error_word_count;
    int cycle_count = 0;
    int words_sent  = 0;
    int phase_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    memory_region_normalizer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts the region lists and compares
    region_list_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .item             (item),
        .done             (done),
        .result           (result),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .pending          (pending),
        .checked_count    (checked_count),
        .error_word_count (error_word_count)
    );

    // guard against a hung handshake
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("memory_region_normalizer_core test failed");
            $finish;
        end
    end

    // present a word from the falling edge and hold it until the block takes it;
    // start stays high afterwards so that back-to-back words need no extra edge
    task automatic send_word(range_in_t w);
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_range(logic [CELL_W-1:0] bu, logic [CELL_W-1:0] bl,
                              logic [CELL_W-1:0] su, logic [CELL_W-1:0] sl, logic fin);
        range_in_t w;
        w.base_upper_cell = bu;
        w.base_lower_cell = bl;
        w.size_upper_cell = su;
        w.size_lower_cell = sl;
        w.final_range     = fin;
        send_word(w);
    endtask

    // sender gap of length n, start low on every falling edge of it
    task automatic pause(int n);
        repeat (n) begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // hold off until every expected word is back and the block has gone quiet;
    // a non-final word leaves no result behind, hence the extra drain
    task automatic settle();
        pause(1);
        while (pending != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // the cell count registers only keep their two low bits, so the rest is junk
    task automatic set_config(logic [CELLS_W-1:0] ac, logic [CELLS_W-1:0] sc,
                              logic [CAP_W-1:0] cap);
        logic [CFG_DATA_W-1:0] d;
        settle();
        d = CFG_DATA_W'($urandom);
        d[CELLS_W-1:0] = ac;
        write_reg(REG_ADDR_CELLS, d);
        d = CFG_DATA_W'($urandom);
        d[CELLS_W-1:0] = sc;
        write_reg(REG_SIZE_CELLS, d);
        write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
        phase_count++;
    endtask

    // a range near the list window, mostly well formed, sometimes noise
    function automatic range_in_t make_range(logic [ADDR_W-1:0] window, bit fin);
        range_in_t         w;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        base = window + 64'($urandom_range(0, 48)) * 64'h1000;
        if ($urandom_range(0, 1) == 1)
            base = base + 64'($urandom_range(1, 12'hfff));
        size = 64'($urandom_range(1, 10)) * 64'h1000;
        if ($urandom_range(0, 1) == 1)
            size = size + 64'($urandom_range(0, 12'hfff));
        case ($urandom_range(0, 11))
            // raw cells, every bit free
            0: begin
                base = {$urandom, $urandom};
                size = {$urandom, $urandom};
            end
            // empty range
            1: size = '0;
            // close to the top of the address space: wraps, near-top base or last pages
            2: begin
                base = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 32'h3_0000));
                size = 64'($urandom_range(1, 32'h4_0000));
            end
            // under a page, mostly rounds away
            3: size = 64'($urandom_range(1, 12'hfff));
            default: ;
        endcase
        w.base_upper_cell = base[63:32];
        w.base_lower_cell = base[31:0];
        w.size_upper_cell = size[63:32];
        w.size_lower_cell = size[31:0];
        w.final_range     = fin;
        return w;
    endfunction

    initial begin
        logic [CELLS_W-1:0] ac;
        logic [CELLS_W-1:0] sc;
        logic [CAP_W-1:0]   cap;
        logic [ADDR_W-1:0]  window;
        bit                 cfg_valid;
        int                 phase;
        int                 random_sent;
        int                 phase_words;
        int                 list_len;
        int                 burst_left;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed lists on the reset settings: two cells each, capacity 16
        // an empty range alone gives the no-regions word
        send_range('0, '0, '0, '0, 1'b1);
        // overlap, touching ends, equal starts, rounding and out-of-order starts
        send_range(32'h1, 32'h0, 32'h0, 32'h3000, 1'b0);
        send_range(32'h0, 32'h5123, 32'h0, 32'h2fff, 1'b0);
        send_range(32'h1, 32'h2000, 32'h0, 32'h2000, 1'b0);
        send_range(32'h0, 32'h8000, 32'h0, 32'h1000, 1'b0);
        send_range(32'h0, 32'h6000, 32'h0, 32'h1000, 1'b0);
        send_range(32'h0, 32'h1001, 32'h0, 32'h1000, 1'b0);
        // range that wraps past the top
        send_range(32'hffff_ffff, 32'h0, 32'h0001_0000, 32'h0, 1'b0);
        // base within a page of the top
        send_range(32'hffff_ffff, 32'hffff_f001, 32'h0, 32'h1, 1'b0);
        // highest aligned base, size shrinks to nothing
        send_range(32'hffff_ffff, 32'hffff_f000, 32'h0, 32'hfff, 1'b0);
        // all ones, dropped, closes the list
        send_range(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        // last full page below the top
        send_range(32'hffff_ffff, 32'hffff_e000, 32'h0, 32'h1000, 1'b1);

        // capacity of one: second range overflows, later ranges ignored
        set_config(CELLS_TWO, CELLS_TWO, CAP_W'(1));
        send_range(32'h0, 32'h4000, 32'h0, 32'h1000, 1'b0);
        send_range(32'h0, 32'h1000, 32'h0, 32'h1000, 1'b0);
        send_range(32'h0, 32'h9000, 32'h0, 32'h1000, 1'b1);
        // fresh list after the overflow
        send_range(32'h0, 32'h2000, 32'h0, 32'h1000, 1'b1);

        // one cell each: upper cells must be ignored
        set_config(CELLS_ONE, CELLS_ONE, CAP_W'(16));
        send_range(32'hffff_ffff, 32'hffff_f000, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_range(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h1000, 1'b1);

        // bad cell counts and zero capacity give the no-regions word
        set_config(2'd3, CELLS_TWO, CAP_W'(16));
        send_range(32'h0, 32'h1000, 32'h0, 32'h1000, 1'b1);
        set_config(CELLS_TWO, 2'd0, CAP_W'(16));
        send_range(32'h0, 32'h1000, 32'h0, 32'h1000, 1'b1);
        set_config(CELLS_TWO, CELLS_TWO, CAP_W'(0));
        send_range(32'h0, 32'h1000, 32'h0, 32'h1000, 1'b0);
        send_range(32'h0, 32'h3000, 32'h0, 32'h1000, 1'b1);

        // capacity above the store size, plus a write to the empty index
        set_config(CELLS_TWO, CELLS_TWO, CAP_W'(31));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        send_range(32'h0, 32'h7000, 32'h0, 32'h2000, 1'b1);

        // random phases: first the fixed corners, then random settings
        phase       = 0;
        random_sent = 0;
        burst_left  = 0;
        while (random_sent < RANDOM_WORDS) begin
            case (phase)
                0: begin ac = CELLS_TWO; sc = CELLS_TWO; cap = CAP_W'(16); end
                1: begin ac = CELLS_ONE; sc = CELLS_ONE; cap = CAP_W'(16); end
                2: begin ac = CELLS_ONE; sc = CELLS_TWO; cap = CAP_W'(4);  end
                3: begin ac = CELLS_TWO; sc = CELLS_ONE; cap = CAP_W'(1);  end
                4: begin ac = CELLS_TWO; sc = CELLS_TWO; cap = CAP_W'(31); end
                5: begin ac = CELLS_TWO; sc = CELLS_TWO; cap = CAP_W'(0);  end
                6: begin ac = 2'd3;      sc = CELLS_TWO; cap = CAP_W'(16); end
                7: begin ac = CELLS_TWO; sc = 2'd0;      cap = CAP_W'(16); end
                default: begin
                    ac = ($urandom_range(0, 9) == 0) ? CELLS_W'($urandom)
                                                     : CELLS_W'($urandom_range(1, 2));
                    sc = ($urandom_range(0, 9) == 0) ? CELLS_W'($urandom)
                                                     : CELLS_W'($urandom_range(1, 2));
                    if ($urandom_range(0, 7) == 0)
                        cap = CAP_W'($urandom_range(0, 31));
                    else if ($urandom_range(0, 1) == 1)
                        cap = CAP_W'(16);
                    else
                        cap = CAP_W'($urandom_range(1, 16));
                end
            endcase
            set_config(ac, sc, cap);
            cfg_valid = (ac == CELLS_ONE || ac == CELLS_TWO) &&
                        (sc == CELLS_ONE || sc == CELLS_TWO) && cap != '0;
            phase_words = 0;
            // an invalid setting only answers the final word, so keep it short
            while (phase_words < (cfg_valid ? 40 : 8)) begin
                list_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                       : $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0: window = '0;
                    1: window = {32'h0, $urandom & 32'hfff0_0000};
                    default: window = {$urandom, $urandom & 32'hfff0_0000};
                endcase
                for (int k = 0; k < list_len; k++) begin
                    // bursts of back-to-back words with random gaps between
                    if (burst_left == 0) begin
                        pause($urandom_range(1, 24));
                        burst_left = $urandom_range(1, 12);
                    end
                    send_word(make_range(window, k == list_len - 1));
                    burst_left--;
                    phase_words++;
                    if (cfg_valid)
                        random_sent++;
                end
                // now and then wait for the whole list to come back
                if ($urandom_range(0, 7) == 0)
                    settle();
            end
            phase++;
        end

        settle();
        $display("run covered %0d range words over %0d register settings", words_sent,
                 phase_count);
        $display("%0d result words checked, %0d of them error or empty words",
                 checked_count, error_word_count);
        if (error_count == 0 && pending == 0) begin
            $display("memory_region_normalizer_core test passed");
        end
        else begin
            $display("memory_region_normalizer_core test failed");
        end
        $finish;
    end

endmodule
